FILE: src/csp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg: shared types and helpers of the color string parser
// Parser state record, result record, kind codes and field-close logic.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int CharW = 8;
    localparam int ChanW = 8;
    localparam int KindW = 3;
    localparam int NumChan = 4;

    localparam logic [KindW-1:0] KIND_HEX6 = 3'd0;
    localparam logic [KindW-1:0] KIND_HEX8 = 3'd1;
    localparam logic [KindW-1:0] KIND_RGB = 3'd2;
    localparam logic [KindW-1:0] KIND_RGBA = 3'd3;
    localparam logic [KindW-1:0] KIND_DEFAULT = 3'd4;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [ChanW-1:0] CHAN_FULL = 8'hFF;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic                            seen_content;
        logic                            leads_with_hash;
        logic [3:0]                      trimmed_length;
        logic [3:0]                      pending_blanks;
        logic [31:0]                     hex_value;
        logic                            hex_running;
        logic                            hex_any_digit;
        logic                            saw_comma;
        phase_t                          field_phase;
        logic [31:0]                     field_magnitude;
        logic                            field_negative;
        logic                            field_overflow;
        logic [NumChan-1:0][ChanW-1:0]   channel_store;
        logic [2:0]                      field_count;
    } csp_state_t;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
        logic [KindW-1:0] kind;
    } csp_color_t;

    localparam csp_state_t CSP_STATE_RESET = '{
        seen_content:    1'b0,
        leads_with_hash: 1'b0,
        trimmed_length:  4'd0,
        pending_blanks:  4'd0,
        hex_value:       32'd0,
        hex_running:     1'b1,
        hex_any_digit:   1'b0,
        saw_comma:       1'b0,
        field_phase:     PH_LEAD,
        field_magnitude: 32'd0,
        field_negative:  1'b0,
        field_overflow:  1'b0,
        channel_store:   '0,
        field_count:     3'd0
    };

    // Close the current decimal field: clamp, store, clear.
    function automatic csp_state_t finish_field(input csp_state_t s);
        csp_state_t       r;
        logic [ChanW-1:0] v;
        r = s;
        if (s.field_overflow || s.field_negative || s.field_magnitude[31])
        begin
            v = '0;
        end
        else if (s.field_magnitude > 32'd255)
        begin
            v = CHAN_FULL;
        end
        else
        begin
            v = s.field_magnitude[ChanW-1:0];
        end
        if (s.field_count < 3'd4)
        begin
            r.channel_store[s.field_count[1:0]] = v;
            r.field_count = s.field_count + 3'd1;
        end
        r.field_phase = PH_LEAD;
        r.field_magnitude = '0;
        r.field_negative = 1'b0;
        r.field_overflow = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/csp_char_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_char_if: character word channel
// Valid/ready channel carrying one character byte and its end mark.
// ----------------------------------------------------------------------------
interface csp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       ch_present;
    logic       last;

    modport source (output valid, output ch, output ch_present, output last,
                    input ready);
    modport sink (input valid, input ch, input ch_present, input last,
                  output ready);
endinterface
`default_nettype wire

FILE: src/csp_color_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_color_if: color result channel
// Valid/ready channel carrying four channel codes and the result kind.
// ----------------------------------------------------------------------------
interface csp_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [2:0] kind;

    modport source (output valid, output red, output green, output blue,
                    output alpha, output kind, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input alpha, input kind, output ready);
endinterface
`default_nettype wire

FILE: src/color_string_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// color_string_parser: streaming RGBA color text parser
// Reads a color string one character per word; gives one color per string.
// ----------------------------------------------------------------------------
// Accepts one character word per clock, except while stalled, with no gaps between
// strings. A word is captured in an input register; from there the
// parser state (hex accumulator, length counters, decimal field
// accumulator, channel store) is updated by one pass of logic, and on the
// word marked last the color is written into the result register, which
// then holds the color until the sink takes it. The result
// register stalls the input only when a finished color is still waiting
// and another string end is about to land on it. Hex text of length 6 or
// 8 (after trimming blanks and one leading '#') gives kinds hex6/hex8;
// three or more comma-separated decimal fields, clamped to 0..255, give
// rgb/rgba (alpha 255 for rgb); anything else gives the default kind with
// all channels zero. State clears after every string end.
// ----------------------------------------------------------------------------
module color_string_parser
    import csp_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    csp_char_if.sink      chars,
    csp_color_if.source   color
);

    // input register
    logic             in_valid_reg;
    logic [CharW-1:0] in_ch_reg;
    logic             in_present_reg;
    logic             in_last_reg;

    // parser state and result register
    csp_state_t st_reg, st_next;
    logic       out_valid_reg, out_valid_next;
    csp_color_t out_reg;

    csp_state_t st_char;  // state after the held character
    csp_color_t res;
    logic       advance;

    // stall only when a string end would overwrite a waiting color
    assign advance = in_valid_reg &&
                     (!in_last_reg || !out_valid_reg || color.ready);
    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            in_ch_reg <= chars.ch;
            in_present_reg <= chars.ch_present;
            in_last_reg <= chars.last;
        end
    end

    // per-character update
    logic        blank, is_digit, hex_ok;
    logic [3:0]  hex_nib, dig;
    logic [5:0]  len_sum;
    logic [35:0] mag_x10;

    always_comb
    begin
        st_char = st_reg;
        blank = (in_ch_reg == 8'h20) || (in_ch_reg == 8'h09);
        is_digit = (in_ch_reg >= "0") && (in_ch_reg <= "9");
        dig = in_ch_reg[3:0];
        hex_ok = 1'b1;
        hex_nib = dig;
        if (is_digit)
        begin
            hex_nib = dig;
        end
        else if (in_ch_reg >= "a" && in_ch_reg <= "f")
        begin
            hex_nib = 4'(in_ch_reg - "a" + 8'd10);
        end
        else if (in_ch_reg >= "A" && in_ch_reg <= "F")
        begin
            hex_nib = 4'(in_ch_reg - "A" + 8'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
        len_sum = {2'b0, st_reg.trimmed_length} + {2'b0, st_reg.pending_blanks}
                  + 6'd1;
        mag_x10 = ({4'b0, st_reg.field_magnitude} << 3)
                  + ({4'b0, st_reg.field_magnitude} << 1) + {32'b0, dig};

        if (in_present_reg)
        begin
            // hex bookkeeping
            if (blank)
            begin
                if (st_reg.seen_content)
                begin
                    st_char.hex_running = 1'b0;
                    if (st_reg.pending_blanks != 4'd15)
                    begin
                        st_char.pending_blanks = st_reg.pending_blanks + 4'd1;
                    end
                end
            end
            else if (!st_reg.seen_content && in_ch_reg == "#")
            begin
                st_char.seen_content = 1'b1;
                st_char.leads_with_hash = 1'b1;
            end
            else
            begin
                st_char.seen_content = 1'b1;
                if (st_reg.hex_running && hex_ok)
                begin
                    st_char.hex_value = {st_reg.hex_value[27:0], hex_nib};
                    st_char.hex_any_digit = 1'b1;
                end
                else
                begin
                    st_char.hex_running = 1'b0;
                end
                st_char.trimmed_length = (len_sum > 6'd15) ? 4'd15 : len_sum[3:0];
                st_char.pending_blanks = '0;
            end

            // decimal fields
            if (in_ch_reg == ",")
            begin
                st_char.saw_comma = 1'b1;
                st_char = finish_field(st_char);
            end
            else if (is_digit)
            begin
                if (st_reg.field_phase == PH_LEAD || st_reg.field_phase == PH_SIGN)
                begin
                    st_char.field_magnitude = {28'b0, dig};
                    st_char.field_phase = PH_DIGITS;
                end
                else if (st_reg.field_phase == PH_DIGITS)
                begin
                    if (mag_x10 > {4'b0, MAG_CAP})
                    begin
                        st_char.field_overflow = 1'b1;
                        st_char.field_magnitude = MAG_CAP;
                    end
                    else
                    begin
                        st_char.field_magnitude = mag_x10[31:0];
                    end
                end
            end
            else if (st_reg.field_phase == PH_LEAD)
            begin
                if (in_ch_reg == "-")
                begin
                    st_char.field_negative = 1'b1;
                    st_char.field_phase = PH_SIGN;
                end
                else if (!blank)
                begin
                    st_char.field_phase = PH_STOP;
                end
            end
            else
            begin
                st_char.field_phase = PH_STOP;
            end
        end
    end

    csp_result u_result (
        .st    (st_char),
        .color (res)
    );

    always_comb
    begin
        st_next = st_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && color.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            if (in_last_reg)
            begin
                st_next = CSP_STATE_RESET;
                out_valid_next = 1'b1;
            end
            else
            begin
                st_next = st_char;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= CSP_STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_reg <= res;
        end
    end

    assign color.valid = out_valid_reg;
    assign color.red = out_reg.red;
    assign color.green = out_reg.green;
    assign color.blue = out_reg.blue;
    assign color.alpha = out_reg.alpha;
    assign color.kind = out_reg.kind;

endmodule
`default_nettype wire

FILE: src/csp_result.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_result: end-of-string classifier
// Closes the open decimal field and picks hex, decimal or default color.
// ----------------------------------------------------------------------------
module csp_result
    import csp_pkg::*;
(
    input  csp_state_t st,
    output csp_color_t color
);

    csp_state_t fin;

    always_comb
    begin
        fin = finish_field(st);
        color = '{red: '0, green: '0, blue: '0, alpha: '0, kind: KIND_DEFAULT};
        if (fin.seen_content)
        begin
            if (!fin.saw_comma && fin.hex_any_digit && fin.trimmed_length == 4'd6)
            begin
                color.red = fin.hex_value[23:16];
                color.green = fin.hex_value[15:8];
                color.blue = fin.hex_value[7:0];
                color.alpha = CHAN_FULL;
                color.kind = KIND_HEX6;
            end
            else if (!fin.saw_comma && fin.hex_any_digit &&
                     fin.trimmed_length == 4'd8)
            begin
                color.red = fin.hex_value[31:24];
                color.green = fin.hex_value[23:16];
                color.blue = fin.hex_value[15:8];
                color.alpha = fin.hex_value[7:0];
                color.kind = KIND_HEX8;
            end
            else if (fin.saw_comma && fin.field_count >= 3'd3)
            begin
                color.red = fin.channel_store[0];
                color.green = fin.channel_store[1];
                color.blue = fin.channel_store[2];
                if (fin.field_count >= 3'd4)
                begin
                    color.alpha = fin.channel_store[3];
                    color.kind = KIND_RGBA;
                end
                else
                begin
                    color.alpha = CHAN_FULL;
                    color.kind = KIND_RGB;
                end
            end
        end
    end

endmodule
`default_nettype wire
